>>> src/whole_word_replace_stream_macros.svh
// Assertion helpers for the RTL file whole_word_replace_stream.sv.
`ifndef WHOLE_WORD_REPLACE_STREAM_MACROS_SVH
`define WHOLE_WORD_REPLACE_STREAM_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define WWRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define WWRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/wwrs_pkg.sv
package wwrs_pkg;

  localparam int MAX_WORD   = 16;
  localparam int WIN_DEPTH  = MAX_WORD + 1;
  localparam int PTR_W      = $clog2(WIN_DEPTH);
  localparam int RING_DEPTH = 2 ** PTR_W;
  localparam int FILL_W     = $clog2(WIN_DEPTH + 1);
  localparam int CNT_W      = $clog2(MAX_WORD + 1);
  localparam int WORD_BYTES = 16;
  localparam int LEN_W      = 5;
  localparam int DATA_W     = 64;
  localparam int IDX_W      = 3;

  // Register indexes of the configuration port
  localparam logic [IDX_W-1:0] REG_SEARCH_LOW     = 3'd0;
  localparam logic [IDX_W-1:0] REG_SEARCH_HIGH    = 3'd1;
  localparam logic [IDX_W-1:0] REG_SEARCH_LENGTH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_REPLACE_LOW    = 3'd3;
  localparam logic [IDX_W-1:0] REG_REPLACE_HIGH   = 3'd4;
  localparam logic [IDX_W-1:0] REG_REPLACE_LENGTH = 3'd5;

  function automatic logic is_word_char(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A);
  endfunction

  // Byte i of a 16-byte word, first character in the low byte; zero past the end.
  function automatic logic [7:0] word_byte(input logic [2*DATA_W-1:0] w,
                                           input logic [CNT_W-1:0] i);
    logic [7:0] r;
    r = '0;
    for (int k = 0; k < WORD_BYTES; k++) begin
      if (int'(i) == k) r = w[k*8 +: 8];
    end
    return r;
  endfunction

  // Saturate a programmed length to MAX_WORD.
  function automatic logic [CNT_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    return (int'(v) > MAX_WORD) ? CNT_W'(MAX_WORD) : CNT_W'(v);
  endfunction

endpackage

>>> src/whole_word_replace_stream.sv
// Whole-word find and replace over a byte stream.
// Text requests arrive on text_valid/text_ready (text_byte, text_last); rewritten
// bytes leave on result_valid/result_ready (out_byte, out_valid, out_last).
// Configuration requests (cfg_valid/cfg_ready, cfg_index, cfg_data) load the
// search and replacement words and lengths and restart the text.
// A small sequencer drives one byte compare unit over a 32-slot ring that holds
// the lookahead window. The block takes one text byte at a time and is busy until
// its decision is done. A byte that only fills the window returns to idle; a
// pass-through decision runs the check, any compares, the pass step and the next
// step; a whole-word match runs the check, the compares, the boundary test, the
// replacement bytes and the next step (sl, rl = word lengths).
// The final byte flushes the window by repeating decisions, plus a closing
// step that emits the last item (an empty marker with out_valid=0 if the flush
// produced no byte). The compare loop, one byte per cycle, sets the rate.
// During a flush one produced byte is parked so the final one can carry out_last.
// A stalled receiver holds the output register and the sequencer waits on it.
// Reset (rst, synchronous) empties the window, clears all requests in flight and
// loads the default registers: search length 1, replacement length 0.
`include "whole_word_replace_stream_macros.svh"

module whole_word_replace_stream (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         text_valid,
  output logic                         text_ready,
  input  logic [7:0]                   text_byte,
  input  logic                         text_last,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [7:0]                   out_byte,
  output logic                         out_valid,
  output logic                         out_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [wwrs_pkg::IDX_W-1:0]   cfg_index,
  input  logic [wwrs_pkg::DATA_W-1:0]  cfg_data
);
  import wwrs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_BOUND = 3'd3;
  localparam logic [2:0] S_REPL  = 3'd4;
  localparam logic [2:0] S_PASS  = 3'd5;
  localparam logic [2:0] S_NEXT  = 3'd6;
  localparam logic [2:0] S_END   = 3'd7;

  logic [2:0]        state;

  // Configuration registers
  logic [DATA_W-1:0] search_low, search_high, replace_low, replace_high;
  logic [LEN_W-1:0]  search_length, replace_length;

  // Lookahead window kept as a ring
  logic [7:0]        ring [RING_DEPTH];
  logic [PTR_W-1:0]  head;
  logic [FILL_W-1:0] fill;
  logic              prev;
  logic              flushing;
  logic [CNT_W-1:0]  idx;

  // Parked byte during a flush
  logic              stage_full;
  logic [7:0]        stage_byte;

  logic [CNT_W-1:0]    sl, rl;
  logic [FILL_W-1:0]   sl_f;
  logic [2*DATA_W-1:0] search_word, repl_word;
  logic [PTR_W-1:0]    rd_addr;
  logic [7:0]          rd_byte, srch_byte, repl_byte, prod_byte;
  logic                out_free, produce_req, can_put, put, end_go, cfg_hit, bound_hit;

  assign sl           = clamp_len(search_length);
  assign rl           = clamp_len(replace_length);
  assign sl_f         = FILL_W'(sl);
  assign search_word  = {search_high, search_low};
  assign repl_word    = {replace_high, replace_low};

  assign cfg_ready  = (state == S_IDLE);
  assign text_ready = (state == S_IDLE) && !cfg_valid;

  // Single read port on the window
  always_comb begin
    case (state)
      S_CMP:   rd_addr = head + PTR_W'(idx);
      S_BOUND: rd_addr = head + PTR_W'(sl);
      default: rd_addr = head;
    endcase
  end
  assign rd_byte   = ring[rd_addr];
  assign srch_byte = word_byte(search_word, idx);
  assign repl_byte = word_byte(repl_word, idx);
  assign bound_hit = (fill > sl_f) ? !is_word_char(rd_byte) : flushing;

  always_comb begin
    produce_req = 1'b0;
    prod_byte   = rd_byte;
    case (state)
      S_PASS: produce_req = 1'b1;
      S_REPL: begin
        produce_req = (idx != rl);
        prod_byte   = repl_byte;
      end
      default: produce_req = 1'b0;
    endcase
  end

  assign out_free = !result_valid || result_ready;
  assign can_put  = flushing ? (!stage_full || out_free) : out_free;
  assign put      = produce_req && can_put;
  assign end_go   = (state == S_END) && out_free;

  always_comb begin
    case (cfg_index)
      REG_SEARCH_LOW, REG_SEARCH_HIGH, REG_SEARCH_LENGTH,
      REG_REPLACE_LOW, REG_REPLACE_HIGH, REG_REPLACE_LENGTH: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      search_low     <= '0;
      search_high    <= '0;
      search_length  <= LEN_W'(1);
      replace_low    <= '0;
      replace_high   <= '0;
      replace_length <= '0;
      head           <= '0;
      fill           <= '0;
      prev           <= 1'b0;
      flushing       <= 1'b0;
      idx            <= '0;
      stage_full     <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            case (cfg_index)
              REG_SEARCH_LOW:     search_low     <= cfg_data;
              REG_SEARCH_HIGH:    search_high    <= cfg_data;
              REG_SEARCH_LENGTH:  search_length  <= cfg_data[LEN_W-1:0];
              REG_REPLACE_LOW:    replace_low    <= cfg_data;
              REG_REPLACE_HIGH:   replace_high   <= cfg_data;
              REG_REPLACE_LENGTH: replace_length <= cfg_data[LEN_W-1:0];
              default: ;
            endcase
            // a known register starts a new text
            if (cfg_hit) begin
              fill <= '0;
              prev <= 1'b0;
            end
          end else if (text_valid) begin
            if (fill != FILL_W'(WIN_DEPTH)) fill <= fill + FILL_W'(1);
            flushing <= text_last;
            // decide once the window holds sl+1 bytes, or flush at the end
            if (text_last || fill >= sl_f) state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (sl != '0 && fill >= sl_f && !prev) begin
            idx   <= '0;
            state <= S_CMP;
          end else begin
            state <= S_PASS;
          end
        end
        S_CMP: begin
          if (rd_byte != srch_byte) state <= S_PASS;
          else if (idx == sl - CNT_W'(1)) state <= S_BOUND;
          else idx <= idx + CNT_W'(1);
        end
        S_BOUND: begin
          if (bound_hit) begin
            idx   <= '0;
            state <= S_REPL;
          end else begin
            state <= S_PASS;
          end
        end
        S_REPL: begin
          if (idx == rl) begin
            // the matched word's last byte sets the boundary for what follows
            head  <= head + PTR_W'(sl);
            fill  <= fill - sl_f;
            prev  <= is_word_char(word_byte(search_word, sl - CNT_W'(1)));
            state <= S_NEXT;
          end else if (put) begin
            idx <= idx + CNT_W'(1);
          end
        end
        S_PASS: begin
          if (put) begin
            prev  <= is_word_char(rd_byte);
            head  <= head + PTR_W'(1);
            fill  <= fill - FILL_W'(1);
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (!flushing) state <= S_IDLE;
          else if (fill != '0) state <= S_CHECK;
          else state <= S_END;
        end
        S_END: begin
          if (end_go) begin
            stage_full   <= 1'b0;
            fill         <= '0;
            prev         <= 1'b0;
            flushing     <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // present a produced byte or the end marker; drop the output once taken
      if ((put && (!flushing || stage_full)) || end_go) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;

      // park a produced byte while flushing
      if (put && flushing) stage_full <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (text_valid && text_ready && fill != FILL_W'(WIN_DEPTH)) begin
      ring[head + PTR_W'(fill)] <= text_byte;
    end
    if (put) begin
      if (!flushing) begin
        out_byte  <= prod_byte;
        out_valid <= 1'b1;
        out_last  <= 1'b0;
      end else begin
        if (stage_full) begin
          out_byte  <= stage_byte;
          out_valid <= 1'b1;
          out_last  <= 1'b0;
        end
        stage_byte <= prod_byte;
      end
    end else if (end_go) begin
      out_byte  <= stage_full ? stage_byte : 8'h00;
      out_valid <= stage_full;
      out_last  <= 1'b1;
    end
  end

  `WWRS_ASSERT_NOW(a_stage_only_in_flush, stage_full, flushing, "parked byte outside a flush")
  `WWRS_ASSERT_NOW(a_empty_is_last, result_valid && !out_valid, out_last,
                   "empty result item without end mark")
  `WWRS_ASSERT_NEXT(a_end_emits_last, end_go, result_valid && out_last,
                    "flush end did not present the final item")
  `WWRS_ASSERT_NOW(a_cmp_has_word, state == S_CMP, (sl != '0) && (fill >= sl_f),
                   "compare running without a full search word in the window")

endmodule
